[rtl/core/stereo_downward_expander_assert.svh]
// Assertion macros for the stereo downward expander.
// Expects clk_i and rst_ni in the scope of use; empty when SYNTHESIS is defined.
`ifndef STEREO_DOWNWARD_EXPANDER_ASSERT_SVH
`define STEREO_DOWNWARD_EXPANDER_ASSERT_SVH
`ifndef SYNTHESIS
`define SED_ASSERT_ALW(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("invariant violated");
`define SED_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication violated");
`define SED_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define SED_ASSERT_ALW(name, expr)
`define SED_ASSERT_IMP(name, ante, cons)
`define SED_ASSERT_NXT(name, ante, cons)
`endif
`endif

[rtl/core/sed_pkg.sv]
// Shared types, constants and table builders for the stereo downward expander.
// No dependencies; imported by every module of the block.
package sed_pkg;

  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned GAIN_W     = 25;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [GAIN_W-1:0]     UNITY_GAIN    = 25'd16777216;
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST = 32'd524288;
  localparam logic [COEF_W-1:0]     EXPONENT_RST  = 16'd819;
  localparam logic [COEF_W-1:0]     ATTACK_RST    = 16'd24109;
  localparam logic [COEF_W-1:0]     RELEASE_RST   = 16'd24109;
  localparam logic [COEF_W-1:0]     DECAY_RST     = 16'd1200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_EXPONENT  = 3'd1,
    CFG_ATTACK    = 3'd2,
    CFG_RELEASE   = 3'd3,
    CFG_DECAY     = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    LUT_LOG,
    LUT_EXP
  } lut_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ENV,
    ST_ENV_ADD,
    ST_TGT,
    ST_NORM,
    ST_LOG_MUL,
    ST_LOG_ADD,
    ST_DIFF,
    ST_POW,
    ST_EXP_MUL,
    ST_EXP_ADD,
    ST_EXP_SHIFT,
    ST_GAIN,
    ST_GAIN_ADD,
    ST_SCALE_L,
    ST_SCALE_R,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic [COEF_W-1:0] exponent;
    logic [COEF_W-1:0] attack;
    logic [COEF_W-1:0] release_c;
    logic [COEF_W-1:0] decay;
  } coef_t;

  typedef struct packed {
    logic             en;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  // log2 knot in Q0.16 by repeated squaring of 1 + i/2^ltb
  function automatic logic [31:0] log_knot(input int unsigned i, input int unsigned ltb);
    logic [63:0] y;
    logic [31:0] r;
    y = (64'd1 << 30) + (64'(i) << (30 - ltb));
    r = '0;
    for (int k = 0; k < 16; k++) begin
      y = (y * y) >> 30;
      r = r << 1;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        r[0] = 1'b1;
      end
    end
    if (i >= (32'd1 << ltb)) begin
      r = 32'd65536;
    end
    return r;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // exp2 knot in Q2.30 as a product of roots 2^(2^-k)
  function automatic logic [31:0] exp_knot(input int unsigned i, input int unsigned ltb);
    logic [63:0] roots [0:10];
    logic [63:0] v;
    roots[0] = 64'd1 << 31;
    for (int k = 1; k <= 10; k++) begin
      roots[k] = (k <= ltb) ? isqrt64(roots[k-1] << 30) : roots[k-1];
    end
    v = 64'd1 << 30;
    for (int k = 0; k < 10; k++) begin
      if (k < ltb && ((i >> k) & 1) == 1) begin
        v = (v * roots[ltb - k]) >> 30;
      end
    end
    if (i >= (32'd1 << ltb)) begin
      v = 64'd1 << 31;
    end
    return v[31:0];
  endfunction

endpackage

[rtl/core/sed_mul.sv]
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on sed_pkg for the request type and widths.
module sed_mul (
  input  logic                      clk_i,
  input  sed_pkg::mul_req_t         req_i,
  output logic [sed_pkg::PROD_W-1:0] prod_o
);
  import sed_pkg::*;

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= PROD_W'(req_i.a) * PROD_W'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

[rtl/core/sed_lut.sv]
// Piecewise-linear log2 and exp2 knot tables, read at idx and idx + 1.
// Depends on sed_pkg for the table builders and the select type.
module sed_lut #(
  parameter int unsigned LOG_TABLE_BITS = 6
) (
  input  sed_pkg::lut_sel_e          sel_i,
  input  logic [LOG_TABLE_BITS-1:0]  idx_i,
  output logic [31:0]                lo_o,
  output logic [31:0]                hi_o
);
  import sed_pkg::*;

  localparam int unsigned KNOTS = 1 << LOG_TABLE_BITS;

  logic [31:0]             log_tab [KNOTS+1];
  logic [31:0]             exp_tab [KNOTS+1];
  logic [LOG_TABLE_BITS:0] idx_lo;
  logic [LOG_TABLE_BITS:0] idx_hi;

  for (genvar i = 0; i <= KNOTS; i++) begin : g_knot
    assign log_tab[i] = log_knot(i, LOG_TABLE_BITS);
    assign exp_tab[i] = exp_knot(i, LOG_TABLE_BITS);
  end

  assign idx_lo = {1'b0, idx_i};
  assign idx_hi = idx_lo + 1'b1;

  always_comb begin
    case (sel_i)
      LUT_EXP: begin
        lo_o = exp_tab[idx_lo];
        hi_o = exp_tab[idx_hi];
      end
      default: begin
        lo_o = log_tab[idx_lo];
        hi_o = log_tab[idx_hi];
      end
    endcase
  end

endmodule

[rtl/core/sed_core.sv]
// Sequencer and datapath: envelope, log-domain gain target, smoothing, scaling.
// Depends on sed_pkg, sed_mul and sed_lut.
module sed_core #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned LOG_TABLE_BITS = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [SAMPLE_BITS-2:0]            threshold_i,
  input  sed_pkg::coef_t                    coef_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]     left_in_i,
  input  logic signed [SAMPLE_BITS-1:0]     right_in_i,
  input  logic                              block_end_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     left_out_o,
  output logic signed [SAMPLE_BITS-1:0]     right_out_o,
  output logic                              block_end_out_o,
  output logic [sed_pkg::GAIN_W-1:0]        gain_o
);
  import sed_pkg::*;

  localparam int unsigned SB      = SAMPLE_BITS;
  localparam int unsigned MAG     = SAMPLE_BITS - 1;
  localparam int unsigned LTB     = LOG_TABLE_BITS;
  localparam int unsigned NSTEP   = $clog2(MAG);
  localparam int unsigned PW      = NSTEP;
  localparam int unsigned STW     = $clog2(NSTEP);
  localparam int unsigned SHW     = NSTEP + 1;
  localparam int unsigned LOG_SH  = MAG - 1 - LTB;
  localparam int unsigned EXP_SH  = 16 - LTB;
  localparam int unsigned LOG_W   = PW + 16;
  localparam int unsigned POW_W   = LOG_W + 4;
  localparam int unsigned N_W     = POW_W - 16;
  localparam int unsigned XSH_W   = N_W + 1;

  st_e                state_q, state_d;
  logic [SB-1:0]      mag_l_q, mag_l_d, mag_r_q, mag_r_d;
  logic               sgn_l_q, sgn_l_d, sgn_r_q, sgn_r_d;
  logic               bend_q, bend_d;
  logic [MAG-1:0]     det_q, det_d;
  logic [MAG-1:0]     env_q, env_d;
  logic [GAIN_W-1:0]  gain_q, gain_d;
  logic [MAG-1:0]     norm_q, norm_d;
  logic [PW-1:0]      lz_q, lz_d;
  logic [STW-1:0]     step_q, step_d;
  logic               pass_q, pass_d;
  logic [31:0]        knot_q, knot_d;
  logic               down_q, down_d;
  logic [PW-1:0]      logp_q, logp_d;
  logic [LOG_W-1:0]   lt_q, lt_d, le_q, le_d;
  logic [15:0]        h_q, h_d;
  logic [31:0]        mant_q, mant_d;
  logic [XSH_W-1:0]   xsh_q, xsh_d;
  logic [GAIN_W-1:0]  tgt_q, tgt_d;
  logic [SB-1:0]      yl_q, yl_d;
  logic               out_valid_q;
  logic [SB-1:0]      left_out_q, right_out_q;
  logic               bend_out_q;
  logic               out_load;
  logic [SB-1:0]      yr;

  mul_req_t           mul_req;
  logic [PROD_W-1:0]  mul_q;
  lut_sel_e           lut_sel;
  logic [LTB-1:0]     lut_idx;
  logic [31:0]        lut_lo, lut_hi;
  logic               lerp_down;
  logic [31:0]        lerp_diff;

  logic [SB-1:0]      raw_l, raw_r, abs_l, abs_r;
  logic [MAG-1:0]     sat_l, sat_r;
  logic [SHW-1:0]     sh_amt;
  logic [31:0]        frac;
  logic [LOG_W-1:0]   logv;
  logic [POW_W-1:0]   pow;
  logic [N_W-1:0]     pow_n;
  logic [15:0]        pow_g;

  sed_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_q)
  );

  sed_lut #(
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_lut (
    .sel_i (lut_sel),
    .idx_i (lut_idx),
    .lo_o  (lut_lo),
    .hi_o  (lut_hi)
  );

  function automatic logic [SB-1:0] scale_sat(input logic [PROD_W-1:0] p, input logic neg);
    logic [SB:0]   y;
    logic [SB-1:0] r;
    y = p[24 +: SB+1];
    if (!neg) begin
      r = (y > (SB+1)'({1'b0, {(SB-1){1'b1}}})) ? {1'b0, {(SB-1){1'b1}}} : y[SB-1:0];
    end else begin
      r = (y > (SB+1)'({1'b1, {(SB-1){1'b0}}})) ? {1'b1, {(SB-1){1'b0}}} : ~y[SB-1:0] + 1'b1;
    end
    return r;
  endfunction

  assign raw_l = left_in_i;
  assign raw_r = right_in_i;
  assign abs_l = raw_l[SB-1] ? ~raw_l + 1'b1 : raw_l;
  assign abs_r = raw_r[SB-1] ? ~raw_r + 1'b1 : raw_r;
  assign sat_l = abs_l[SB-1] ? {MAG{1'b1}} : abs_l[MAG-1:0];
  assign sat_r = abs_r[SB-1] ? {MAG{1'b1}} : abs_r[MAG-1:0];

  assign lerp_down = lut_hi < lut_lo;
  assign lerp_diff = lerp_down ? lut_lo - lut_hi : lut_hi - lut_lo;
  assign sh_amt    = SHW'(1) << step_q;
  assign pow       = mul_q[POW_W+11:12];
  assign pow_n     = pow[POW_W-1:16];
  assign pow_g     = pow[15:0];
  assign yr        = scale_sat(mul_q, sgn_r_q);

  always_comb begin
    state_d  = state_q;
    mag_l_d  = mag_l_q;
    mag_r_d  = mag_r_q;
    sgn_l_d  = sgn_l_q;
    sgn_r_d  = sgn_r_q;
    bend_d   = bend_q;
    det_d    = det_q;
    env_d    = env_q;
    gain_d   = gain_q;
    norm_d   = norm_q;
    lz_d     = lz_q;
    step_d   = step_q;
    pass_d   = pass_q;
    knot_d   = knot_q;
    down_d   = down_q;
    logp_d   = logp_q;
    lt_d     = lt_q;
    le_d     = le_q;
    h_d      = h_q;
    mant_d   = mant_q;
    xsh_d    = xsh_q;
    tgt_d    = tgt_q;
    yl_d     = yl_q;
    mul_req  = '0;
    lut_sel  = LUT_LOG;
    lut_idx  = norm_q[MAG-2 -: LTB];
    frac     = '0;
    logv     = '0;
    in_ready_o = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mag_l_d = abs_l;
          mag_r_d = abs_r;
          sgn_l_d = raw_l[SB-1];
          sgn_r_d = raw_r[SB-1];
          bend_d  = block_end_i;
          det_d   = (sat_l > sat_r) ? sat_l : sat_r;
          state_d = ST_ENV;
        end
      end
      ST_ENV: begin
        if (det_q >= env_q) begin
          env_d   = det_q;
          state_d = ST_TGT;
        end else begin
          mul_req = '{en: 1'b1, a: MUL_W'(coef_i.decay), b: MUL_W'(env_q - det_q)};
          state_d = ST_ENV_ADD;
        end
      end
      ST_ENV_ADD: begin
        env_d   = det_q + MAG'(mul_q >> 16);
        state_d = ST_TGT;
      end
      ST_TGT: begin
        if (threshold_i == '0 || env_q >= threshold_i || coef_i.exponent == '0) begin
          tgt_d   = UNITY_GAIN;
          state_d = ST_GAIN;
        end else if (env_q == '0) begin
          tgt_d   = '0;
          state_d = ST_GAIN;
        end else begin
          norm_d  = threshold_i;
          lz_d    = '0;
          step_d  = STW'(NSTEP - 1);
          pass_d  = 1'b0;
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if ((norm_q >> (SHW'(MAG) - sh_amt)) == '0) begin
          norm_d = norm_q << sh_amt;
          lz_d   = lz_q + PW'(sh_amt);
        end
        if (step_q == '0) begin
          state_d = ST_LOG_MUL;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_LOG_MUL: begin
        knot_d  = lut_lo;
        down_d  = lerp_down;
        logp_d  = PW'(MAG - 1) - lz_q;
        mul_req = '{en: 1'b1, a: lerp_diff, b: MUL_W'(norm_q[LOG_SH-1:0])};
        state_d = ST_LOG_ADD;
      end
      ST_LOG_ADD: begin
        frac = down_q ? knot_q - 32'(mul_q >> LOG_SH) : knot_q + 32'(mul_q >> LOG_SH);
        logv = {logp_q, 16'b0} + LOG_W'(frac);
        if (!pass_q) begin
          lt_d    = logv;
          norm_d  = env_q;
          lz_d    = '0;
          step_d  = STW'(NSTEP - 1);
          pass_d  = 1'b1;
          state_d = ST_NORM;
        end else begin
          le_d    = logv;
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        if (lt_q <= le_q) begin
          tgt_d   = UNITY_GAIN;
          state_d = ST_GAIN;
        end else begin
          mul_req = '{en: 1'b1, a: MUL_W'(coef_i.exponent), b: MUL_W'(lt_q - le_q)};
          state_d = ST_POW;
        end
      end
      ST_POW: begin
        if (pow_g == '0) begin
          mant_d  = 32'd1 << 30;
          xsh_d   = XSH_W'(pow_n) + XSH_W'(6);
          state_d = ST_EXP_SHIFT;
        end else begin
          h_d     = 16'd0 - pow_g;
          xsh_d   = XSH_W'(pow_n) + XSH_W'(7);
          state_d = ST_EXP_MUL;
        end
      end
      ST_EXP_MUL: begin
        lut_sel = LUT_EXP;
        lut_idx = h_q[15 -: LTB];
        knot_d  = lut_lo;
        down_d  = lerp_down;
        mul_req = '{en: 1'b1, a: lerp_diff, b: MUL_W'(h_q[EXP_SH-1:0])};
        state_d = ST_EXP_ADD;
      end
      ST_EXP_ADD: begin
        mant_d  = down_q ? knot_q - 32'(mul_q >> EXP_SH) : knot_q + 32'(mul_q >> EXP_SH);
        state_d = ST_EXP_SHIFT;
      end
      ST_EXP_SHIFT: begin
        if (xsh_q >= XSH_W'(31)) begin
          tgt_d = '0;
        end else begin
          tgt_d = GAIN_W'(mant_q >> xsh_q[4:0]);
        end
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        if (tgt_q < gain_q) begin
          down_d  = 1'b1;
          mul_req = '{en: 1'b1, a: MUL_W'(coef_i.attack), b: MUL_W'(gain_q - tgt_q)};
        end else begin
          down_d  = 1'b0;
          mul_req = '{en: 1'b1, a: MUL_W'(coef_i.release_c), b: MUL_W'(tgt_q - gain_q)};
        end
        state_d = ST_GAIN_ADD;
      end
      ST_GAIN_ADD: begin
        gain_d  = down_q ? tgt_q + GAIN_W'(mul_q >> 16) : tgt_q - GAIN_W'(mul_q >> 16);
        state_d = ST_SCALE_L;
      end
      ST_SCALE_L: begin
        mul_req = '{en: 1'b1, a: MUL_W'(mag_l_q), b: MUL_W'(gain_q)};
        state_d = ST_SCALE_R;
      end
      ST_SCALE_R: begin
        yl_d    = scale_sat(mul_q, sgn_l_q);
        mul_req = '{en: 1'b1, a: MUL_W'(mag_r_q), b: MUL_W'(gain_q)};
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      env_q       <= '0;
      gain_q      <= UNITY_GAIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      env_q   <= env_d;
      gain_q  <= gain_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_l_q <= mag_l_d;
    mag_r_q <= mag_r_d;
    sgn_l_q <= sgn_l_d;
    sgn_r_q <= sgn_r_d;
    bend_q  <= bend_d;
    det_q   <= det_d;
    norm_q  <= norm_d;
    lz_q    <= lz_d;
    step_q  <= step_d;
    pass_q  <= pass_d;
    knot_q  <= knot_d;
    down_q  <= down_d;
    logp_q  <= logp_d;
    lt_q    <= lt_d;
    le_q    <= le_d;
    h_q     <= h_d;
    mant_q  <= mant_d;
    xsh_q   <= xsh_d;
    tgt_q   <= tgt_d;
    yl_q    <= yl_d;
    if (out_load) begin
      left_out_q  <= yl_q;
      right_out_q <= yr;
      bend_out_q  <= bend_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_out_o      = left_out_q;
  assign right_out_o     = right_out_q;
  assign block_end_out_o = bend_out_q;
  assign gain_o          = gain_q;

endmodule

[rtl/core/stereo_downward_expander.sv]
// Top level of the stereo downward expander: register file and core.
// Depends on sed_pkg, sed_core and stereo_downward_expander_assert.svh.
//
//   channel  dir  handshake                 word
//   in       in   in_valid_i / in_ready_o   left_in_i, right_in_i, block_end_i
//   out      out  out_valid_o / out_ready_i left_out_o, right_out_o, block_end_out_o
//   cfg      in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One word takes the shortest path through the core when the target gain is unity
// and the envelope rises, and the longest below threshold: two leading-zero
// searches of clog2(SAMPLE_BITS-1) steps each plus one pass per product through
// the single shared multiplier.
// Reset clears the envelope to zero, the gain to unity and loads register defaults.
// A finished word waits in the output register; the next input word is taken
// meanwhile, and the core holds at its last step until the output slot frees.
// cfg_ready_o is always high.
`include "stereo_downward_expander_assert.svh"
module stereo_downward_expander #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned LOG_TABLE_BITS = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sed_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sed_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]     left_in_i,
  input  logic signed [SAMPLE_BITS-1:0]     right_in_i,
  input  logic                              block_end_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     left_out_o,
  output logic signed [SAMPLE_BITS-1:0]     right_out_o,
  output logic                              block_end_out_o
);
  import sed_pkg::*;

  localparam int unsigned MAG = SAMPLE_BITS - 1;

  logic [MAG-1:0]    threshold_q;
  coef_t             coef_q;
  logic [GAIN_W-1:0] gain;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q      <= THRESHOLD_RST[MAG-1:0];
      coef_q.exponent  <= EXPONENT_RST;
      coef_q.attack    <= ATTACK_RST;
      coef_q.release_c <= RELEASE_RST;
      coef_q.decay     <= DECAY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_THRESHOLD: threshold_q      <= cfg_data_i[MAG-1:0];
        CFG_EXPONENT:  coef_q.exponent  <= cfg_data_i[COEF_W-1:0];
        CFG_ATTACK:    coef_q.attack    <= cfg_data_i[COEF_W-1:0];
        CFG_RELEASE:   coef_q.release_c <= cfg_data_i[COEF_W-1:0];
        CFG_DECAY:     coef_q.decay     <= cfg_data_i[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sed_core #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .threshold_i     (threshold_q),
    .coef_i          (coef_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .left_in_i       (left_in_i),
    .right_in_i      (right_in_i),
    .block_end_i     (block_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .left_out_o      (left_out_o),
    .right_out_o     (right_out_o),
    .block_end_out_o (block_end_out_o),
    .gain_o          (gain)
  );

  `SED_ASSERT_ALW(a_gain_max_unity, gain <= UNITY_GAIN)
  `SED_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `SED_ASSERT_IMP(a_result_after_work, $rose(out_valid_o), !$past(in_ready_o))

endmodule
